FILE: hdl/can_pwm_command_decoder_defines.svh
// Assertion macros shared by the CAN PWM command decoder RTL.
// No dependencies; take in with `include before the assertions.
`ifndef CAN_PWM_COMMAND_DECODER_DEFINES_SVH
`define CAN_PWM_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CPCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpcd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CPCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpcd assertion failed");

`endif

FILE: hdl/cpcd_pkg.sv
// Types, constants and helper functions for the CAN PWM command decoder.
// No dependencies; used by every module of the block.
package cpcd_pkg;

  localparam int VALVE_CHANNELS = 2;

  localparam logic [9:0]  LEVEL_MAX    = 10'd1000;
  localparam logic [10:0] MOTOR_OFFSET = 11'd1000;
  localparam logic [16:0] CMP_ONE_MAX  = 17'd66288;

  // floor(y / 125) == (y * RECIP_MUL) >> RECIP_SHIFT for every 23-bit y
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_MUL   = 24'd8589935;

  // register indexes of the configuration port
  localparam logic [2:0] REG_NODE_ID       = 3'd0;
  localparam logic [2:0] REG_VALVE_VARIANT = 3'd1;
  localparam logic [2:0] REG_TIMER_PERIOD  = 3'd2;
  localparam logic [2:0] REG_MOTOR_LOW_ID  = 3'd3;
  localparam logic [2:0] REG_MOTOR_HIGH_ID = 3'd4;
  localparam logic [2:0] REG_VALVE_ONE_ID  = 3'd5;
  localparam logic [2:0] REG_VALVE_TWO_ID  = 3'd6;

  // what a beat does to the compares
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_MOTOR = 2'd1;
  localparam logic [1:0] KIND_VALVE = 2'd2;

  typedef struct packed {
    logic [3:0]  node_id;
    logic        valve_variant;
    logic [15:0] timer_period;
    logic [7:0]  motor_low_id;
    logic [7:0]  motor_high_id;
    logic [7:0]  valve_one_id;
    logic [7:0]  valve_two_id;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [10:0] op_a;
    logic [9:0]  op_b;
    logic        updated;
  } op_t;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic        updated;
    logic [16:0] q_one;
    logic [15:0] q_two;
  } res_t;

  function automatic logic [9:0] slot_value(input logic [63:0] payload, input logic [2:0] k);
    logic [9:0] v;
    unique case (k)
      3'd0:    v = payload[9:0];
      3'd1:    v = payload[19:10];
      3'd2:    v = payload[29:20];
      3'd3:    v = payload[41:32];
      3'd4:    v = payload[51:42];
      3'd5:    v = payload[61:52];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/cpcd_decode.sv
// Frame decode stage: id matching, slot pick, valve level store.
// Depends on cpcd_pkg.
module cpcd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  cpcd_pkg::cfg_t   cfg,
  input  logic             s0_vld,
  input  logic             s0_func,
  input  logic [7:0]       s0_id,
  input  logic [63:0]      s0_payload,
  output cpcd_pkg::op_t    op
);

  logic [9:0]     valve_level_r [cpcd_pkg::VALVE_CHANNELS];
  logic [9:0]     valve_level_nxt [cpcd_pkg::VALVE_CHANNELS];
  cpcd_pkg::op_t  op_r;
  cpcd_pkg::op_t  op_nxt;
  logic           op_vld_r;
  logic           low_node;
  logic           high_node;
  logic [3:0]     k_wide;
  logic [9:0]     v;
  logic [9:0]     v_clamp;

  always_comb begin
    low_node  = (cfg.node_id >= 4'd1) && (cfg.node_id <= 4'd6);
    high_node = (cfg.node_id >= 4'd7) && (cfg.node_id <= 4'd12);
    k_wide    = low_node ? (cfg.node_id - 4'd1) : (cfg.node_id - 4'd7);
    v         = cpcd_pkg::slot_value(s0_payload, k_wide[2:0]);
    v_clamp   = (v > cpcd_pkg::LEVEL_MAX) ? cpcd_pkg::LEVEL_MAX : v;

    for (int i = 0; i < cpcd_pkg::VALVE_CHANNELS; i++) begin
      valve_level_nxt[i] = valve_level_r[i];
    end
    op_nxt         = '0;
    op_nxt.vld     = s0_vld;
    op_nxt.kind    = cpcd_pkg::KIND_NONE;

    priority if (s0_func) begin
      for (int i = 0; i < cpcd_pkg::VALVE_CHANNELS; i++) begin
        valve_level_nxt[i] = '0;
      end
      op_nxt.kind    = cfg.valve_variant ? cpcd_pkg::KIND_VALVE : cpcd_pkg::KIND_MOTOR;
      op_nxt.op_a    = cpcd_pkg::MOTOR_OFFSET;
      op_nxt.updated = 1'b1;
    end else if (s0_id == cfg.motor_low_id && low_node) begin
      if (!cfg.valve_variant) begin
        op_nxt.kind    = cpcd_pkg::KIND_MOTOR;
        op_nxt.op_a    = 11'(v) + cpcd_pkg::MOTOR_OFFSET;
        op_nxt.updated = 1'b1;
      end
    end else if (s0_id == cfg.motor_high_id && high_node) begin
      if (!cfg.valve_variant) begin
        op_nxt.kind    = cpcd_pkg::KIND_MOTOR;
        op_nxt.op_a    = 11'(v) + cpcd_pkg::MOTOR_OFFSET;
        op_nxt.updated = 1'b1;
      end
    end else if (s0_id == cfg.valve_one_id && low_node) begin
      valve_level_nxt[0] = v_clamp;
      if (cfg.valve_variant) begin
        op_nxt.kind    = cpcd_pkg::KIND_VALVE;
        op_nxt.updated = 1'b1;
      end
    end else if (s0_id == cfg.valve_two_id && low_node) begin
      valve_level_nxt[1] = v_clamp;
      if (cfg.valve_variant) begin
        op_nxt.kind    = cpcd_pkg::KIND_VALVE;
        op_nxt.updated = 1'b1;
      end
    end else begin
      op_nxt.kind = cpcd_pkg::KIND_NONE;
    end

    // drive both valves from the new levels; both on means both off
    if (op_nxt.kind == cpcd_pkg::KIND_VALVE) begin
      if (valve_level_nxt[0] != '0 && valve_level_nxt[1] != '0) begin
        op_nxt.op_a = '0;
        op_nxt.op_b = '0;
      end else begin
        op_nxt.op_a = 11'(valve_level_nxt[0]);
        op_nxt.op_b = valve_level_nxt[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
      for (int i = 0; i < cpcd_pkg::VALVE_CHANNELS; i++) begin
        valve_level_r[i] <= '0;
      end
    end else if (adv) begin
      op_vld_r <= op_nxt.vld;
      if (s0_vld) begin
        for (int i = 0; i < cpcd_pkg::VALVE_CHANNELS; i++) begin
          valve_level_r[i] <= valve_level_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r <= op_nxt;
    end
  end

  always_comb begin
    op     = op_r;
    op.vld = op_vld_r;
  end

endmodule

FILE: hdl/cpcd_scale.sv
// Compare scaling: level times timer period, then divide by 2000 or 1000.
// Depends on cpcd_pkg.
module cpcd_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [15:0]      timer_period,
  input  cpcd_pkg::op_t    op,
  output cpcd_pkg::res_t   res
);

  logic        p_vld_r;
  logic [1:0]  p_kind_r;
  logic        p_upd_r;
  logic [26:0] p_one_r;
  logic [25:0] p_two_r;

  logic        m_vld_r;
  logic [1:0]  m_kind_r;
  logic        m_upd_r;
  logic [46:0] m_one_r;
  logic [46:0] m_two_r;

  logic [22:0] y_one;
  logic [22:0] y_two;

  // divide by 16 or 8 first, then by 125 through the reciprocal
  always_comb begin
    y_one = (p_kind_r == cpcd_pkg::KIND_MOTOR) ? p_one_r[26:4] : p_one_r[25:3];
    y_two = p_two_r[25:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
    end else if (adv) begin
      p_vld_r <= op.vld;
      m_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_kind_r <= op.kind;
      p_upd_r  <= op.updated;
      p_one_r  <= 27'(op.op_a) * 27'(timer_period);
      p_two_r  <= 26'(op.op_b) * 26'(timer_period);
      m_kind_r <= p_kind_r;
      m_upd_r  <= p_upd_r;
      m_one_r  <= 47'(y_one) * 47'(cpcd_pkg::RECIP_MUL);
      m_two_r  <= 47'(y_two) * 47'(cpcd_pkg::RECIP_MUL);
    end
  end

  always_comb begin
    res.vld     = m_vld_r;
    res.kind    = m_kind_r;
    res.updated = m_upd_r;
    res.q_one   = m_one_r[cpcd_pkg::RECIP_SHIFT +: 17];
    res.q_two   = m_two_r[cpcd_pkg::RECIP_SHIFT +: 16];
  end

endmodule

FILE: hdl/can_pwm_command_decoder.sv
// CAN PWM command decoder top level: channels, configuration, compare state.
// Depends on cpcd_pkg, cpcd_decode, cpcd_scale and the defines header.
//
// Input beat: in_func (0 CAN frame, 1 link timeout), in_message_id and the
// eight-byte in_payload. Each input beat yields exactly one output beat with
// the current compare values and out_updated set when the beat wrote one.
// Configuration: cfg_index/cfg_data written on cfg_valid; cfg_ready is
// always high. Indexes past the register list are dropped.
// Pipeline: once its input beat is taken into the input register, a beat
// passes through the decode, multiply-by-period, reciprocal-divide and
// output register stages, in that order.
// Throughput: one beat per cycle while out_ready does not hold the pipeline.
// Back-pressure: all stages advance together when the output register is
// empty or taken; while out_ready stays low with a beat waiting, in_ready
// drops and the pipeline holds.
// Reset: synchronous, active low; clears the pipeline, the valve levels,
// both compares and loads the register defaults.
`include "can_pwm_command_decoder_defines.svh"

module can_pwm_command_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_message_id,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_compare_one,
  output logic [15:0] out_compare_two,
  output logic        out_updated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cpcd_pkg::cfg_t  cfg_r;
  cpcd_pkg::op_t   op;
  cpcd_pkg::res_t  res;

  logic        adv;
  logic        s0_vld_r;
  logic        s0_func_r;
  logic [7:0]  s0_id_r;
  logic [63:0] s0_payload_r;

  logic [16:0] cmp_one_r;
  logic [16:0] cmp_one_nxt;
  logic [15:0] cmp_two_r;
  logic [15:0] cmp_two_nxt;

  logic        out_valid_r;
  logic [16:0] out_cmp_one_r;
  logic [15:0] out_cmp_two_r;
  logic        out_upd_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id       <= 4'd1;
      cfg_r.valve_variant <= 1'b0;
      cfg_r.timer_period  <= 16'd1000;
      cfg_r.motor_low_id  <= 8'd0;
      cfg_r.motor_high_id <= 8'd1;
      cfg_r.valve_one_id  <= 8'd2;
      cfg_r.valve_two_id  <= 8'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cpcd_pkg::REG_NODE_ID:       cfg_r.node_id       <= cfg_data[3:0];
        cpcd_pkg::REG_VALVE_VARIANT: cfg_r.valve_variant <= cfg_data[0];
        cpcd_pkg::REG_TIMER_PERIOD:  cfg_r.timer_period  <= cfg_data;
        cpcd_pkg::REG_MOTOR_LOW_ID:  cfg_r.motor_low_id  <= cfg_data[7:0];
        cpcd_pkg::REG_MOTOR_HIGH_ID: cfg_r.motor_high_id <= cfg_data[7:0];
        cpcd_pkg::REG_VALVE_ONE_ID:  cfg_r.valve_one_id  <= cfg_data[7:0];
        cpcd_pkg::REG_VALVE_TWO_ID:  cfg_r.valve_two_id  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_func_r    <= in_func;
      s0_id_r      <= in_message_id;
      s0_payload_r <= in_payload;
    end
  end

  cpcd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .s0_vld     (s0_vld_r),
    .s0_func    (s0_func_r),
    .s0_id      (s0_id_r),
    .s0_payload (s0_payload_r),
    .op         (op)
  );

  cpcd_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .timer_period (cfg_r.timer_period),
    .op           (op),
    .res          (res)
  );

  always_comb begin
    cmp_one_nxt = cmp_one_r;
    cmp_two_nxt = cmp_two_r;
    unique case (res.kind)
      cpcd_pkg::KIND_MOTOR: cmp_one_nxt = res.q_one;
      cpcd_pkg::KIND_VALVE: begin
        cmp_one_nxt = res.q_one;
        cmp_two_nxt = res.q_two;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_one_r   <= '0;
      cmp_two_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.vld;
      if (res.vld) begin
        cmp_one_r <= cmp_one_nxt;
        cmp_two_r <= cmp_two_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      out_cmp_one_r <= cmp_one_nxt;
      out_cmp_two_r <= cmp_two_nxt;
      out_upd_r     <= res.updated;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_compare_one = out_cmp_one_r;
  assign out_compare_two = out_cmp_two_r;
  assign out_updated     = out_upd_r;

  `CPCD_ASSERT_NOW(a_upd_kind, adv && res.vld, (res.kind != cpcd_pkg::KIND_NONE) == res.updated)
  `CPCD_ASSERT_NEXT(a_valve_excl, adv && res.vld && res.kind == cpcd_pkg::KIND_VALVE,
                    out_compare_one == '0 || out_compare_two == '0)
  `CPCD_ASSERT_NOW(a_cmp_range, out_valid_r, out_compare_one <= cpcd_pkg::CMP_ONE_MAX)
  `CPCD_ASSERT_NEXT(a_timeout_upd, adv && res.vld && res.kind == cpcd_pkg::KIND_MOTOR,
                    out_updated && out_compare_one == cmp_one_r)

endmodule
